[hw/rtl/pngcc_pkg.sv]
// pngcc_pkg: shared constants, types and functions for the png chunk checker
// used by the front and queue modules and the top level
package pngcc_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
    localparam logic [31:0] TYPE_IHDR = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT = 32'h49444154;
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;
    localparam logic [31:0] HDR_MIN_LEN = 32'd13;

    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    localparam logic [1:0] RK_DATA = 2'd0;
    localparam logic [1:0] RK_PASS = 2'd1;
    localparam logic [1:0] RK_END  = 2'd2;

    localparam logic [1:0] CK_OTHER = 2'd0;
    localparam logic [1:0] CK_IHDR  = 2'd1;
    localparam logic [1:0] CK_IDAT  = 2'd2;
    localparam logic [1:0] CK_IEND  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_SIG = 3'd1;
    localparam logic [2:0] ST_BAD_CRC = 3'd2;
    localparam logic [2:0] ST_BAD_HDR = 3'd3;
    localparam logic [2:0] ST_NO_DATA = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  data_byte;
        logic [1:0]  chunk_kind;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  bit_depth;
        logic [2:0]  color_type;
        logic [2:0]  channel_count;
        logic [2:0]  status;
        logic        truncated;
    } t_result;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'd137;
            3'd1: v = 8'd80;
            3'd2: v = 8'd78;
            3'd3: v = 8'd71;
            3'd4: v = 8'd13;
            3'd5: v = 8'd10;
            3'd6: v = 8'd26;
            3'd7: v = 8'd10;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [2:0] channels_of(input logic [7:0] color);
        logic [2:0] v;
        case (color)
            8'd0: v = 3'd1;
            8'd2: v = 3'd3;
            8'd4: v = 3'd2;
            8'd6: v = 3'd4;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/pngcc_front.sv]
// pngcc_front: parses the byte stream, checks crc and builds result items
// depends on pngcc_pkg
module pngcc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output logic                o_have,
    output pngcc_pkg::t_result  o_res
);

    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_sig_idx, n_sig_idx;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_len, n_len;
    logic [31:0] r_type, n_type;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_scrc, n_scrc;
    logic [31:0] r_pw, n_pw;
    logic [31:0] r_ph, n_ph;
    logic [7:0]  r_pd, n_pd;
    logic [7:0]  r_pc, n_pc;
    logic        r_pbad, n_pbad;
    logic [31:0] r_hw, n_hw;
    logic [31:0] r_hh, n_hh;
    logic [7:0]  r_hd, n_hd;
    logic [7:0]  r_hc, n_hc;
    logic [2:0]  r_hch, n_hch;
    logic        r_seen, n_seen;

    logic        have;
    logic [1:0]  rkind, ckind, k;
    logic [7:0]  dbyte;
    logic [2:0]  status;
    logic        trunc;
    logic [31:0] cnt1, crc_n;

    always_comb begin
        n_phase = r_phase; n_sig_idx = r_sig_idx; n_cnt = r_cnt; n_len = r_len;
        n_type = r_type; n_crc = r_crc; n_scrc = r_scrc; n_pw = r_pw; n_ph = r_ph;
        n_pd = r_pd; n_pc = r_pc; n_pbad = r_pbad; n_hw = r_hw; n_hh = r_hh;
        n_hd = r_hd; n_hc = r_hc; n_hch = r_hch; n_seen = r_seen;
        have = 1'b0; rkind = pngcc_pkg::RK_DATA; dbyte = 8'd0;
        ckind = pngcc_pkg::CK_OTHER; status = pngcc_pkg::ST_OK; trunc = 1'b0;
        cnt1 = r_cnt + 32'd1;
        crc_n = pngcc_pkg::crc_byte(r_crc, i_byte);
        if (r_type == pngcc_pkg::TYPE_IHDR) k = pngcc_pkg::CK_IHDR;
        else if (r_type == pngcc_pkg::TYPE_IDAT) k = pngcc_pkg::CK_IDAT;
        else if (r_type == pngcc_pkg::TYPE_IEND) k = pngcc_pkg::CK_IEND;
        else k = pngcc_pkg::CK_OTHER;
        if (i_valid && r_phase != pngcc_pkg::PH_DONE) begin
            case (r_phase)
                pngcc_pkg::PH_SIG: begin
                    if (i_byte != pngcc_pkg::sig_byte(r_sig_idx)) begin
                        have = 1'b1; rkind = pngcc_pkg::RK_END;
                        status = pngcc_pkg::ST_BAD_SIG;
                        n_phase = pngcc_pkg::PH_DONE;
                    end else if (r_sig_idx == 3'd7) begin
                        n_sig_idx = 3'd0; n_phase = pngcc_pkg::PH_LEN; n_cnt = 32'd0;
                    end else begin
                        n_sig_idx = r_sig_idx + 3'd1;
                    end
                end
                pngcc_pkg::PH_LEN: begin
                    n_len = {r_len[23:0], i_byte};
                    n_cnt = cnt1;
                    if (cnt1 >= 32'd4) begin
                        n_phase = pngcc_pkg::PH_TYPE; n_cnt = 32'd0;
                        n_type = 32'd0; n_crc = pngcc_pkg::CRC_ONES;
                    end
                end
                pngcc_pkg::PH_TYPE: begin
                    n_type = {r_type[23:0], i_byte};
                    n_crc = crc_n;
                    n_cnt = cnt1;
                    if (cnt1 >= 32'd4) begin
                        n_cnt = 32'd0; n_pw = 32'd0; n_ph = 32'd0; n_pd = 8'd0;
                        n_pc = 8'd0; n_pbad = 1'b0; n_scrc = 32'd0;
                        n_phase = (r_len != 32'd0) ? pngcc_pkg::PH_DATA
                                                   : pngcc_pkg::PH_CRC;
                    end
                end
                pngcc_pkg::PH_DATA: begin
                    n_crc = crc_n;
                    if (k == pngcc_pkg::CK_IHDR) begin
                        if (r_cnt < 32'd4) n_pw = {r_pw[23:0], i_byte};
                        else if (r_cnt < 32'd8) n_ph = {r_ph[23:0], i_byte};
                        else if (r_cnt == 32'd8) n_pd = i_byte;
                        else if (r_cnt == 32'd9) begin
                            n_pc = i_byte;
                            if (pngcc_pkg::channels_of(i_byte) == 3'd0) n_pbad = 1'b1;
                        end else if (r_cnt < pngcc_pkg::HDR_MIN_LEN) begin
                            if (i_byte != 8'd0) n_pbad = 1'b1;
                        end
                    end else if (k == pngcc_pkg::CK_IDAT) begin
                        have = 1'b1; rkind = pngcc_pkg::RK_DATA; dbyte = i_byte;
                        ckind = pngcc_pkg::CK_IDAT;
                    end
                    n_cnt = cnt1;
                    if (cnt1 >= r_len) begin
                        n_cnt = 32'd0; n_phase = pngcc_pkg::PH_CRC;
                    end
                end
                default: begin
                    n_scrc = {r_scrc[23:0], i_byte};
                    n_cnt = cnt1;
                    if (cnt1 >= 32'd4) begin
                        n_cnt = 32'd0; n_phase = pngcc_pkg::PH_LEN; have = 1'b1;
                        if ((r_crc ^ pngcc_pkg::CRC_ONES) != n_scrc) begin
                            rkind = pngcc_pkg::RK_END; status = pngcc_pkg::ST_BAD_CRC;
                            n_phase = pngcc_pkg::PH_DONE;
                        end else if (k == pngcc_pkg::CK_IHDR &&
                                     (r_len < pngcc_pkg::HDR_MIN_LEN || r_pbad)) begin
                            rkind = pngcc_pkg::RK_END; status = pngcc_pkg::ST_BAD_HDR;
                            n_phase = pngcc_pkg::PH_DONE;
                        end else begin
                            if (k == pngcc_pkg::CK_IHDR) begin
                                n_hw = r_pw; n_hh = r_ph; n_hd = r_pd; n_hc = r_pc;
                                n_hch = pngcc_pkg::channels_of(r_pc);
                            end else if (k == pngcc_pkg::CK_IDAT && r_len != 32'd0) begin
                                n_seen = 1'b1;
                            end
                            ckind = k;
                            if (k == pngcc_pkg::CK_IEND) begin
                                rkind = pngcc_pkg::RK_END;
                                status = n_seen ? pngcc_pkg::ST_OK : pngcc_pkg::ST_NO_DATA;
                                n_phase = pngcc_pkg::PH_DONE;
                            end else begin
                                rkind = pngcc_pkg::RK_PASS;
                            end
                        end
                    end
                end
            endcase
            if (n_phase != pngcc_pkg::PH_DONE && i_last) begin
                if (n_phase == pngcc_pkg::PH_SIG) begin
                    status = pngcc_pkg::ST_BAD_SIG; trunc = 1'b0;
                end else begin
                    status = n_seen ? pngcc_pkg::ST_OK : pngcc_pkg::ST_NO_DATA;
                    trunc = !(n_phase == pngcc_pkg::PH_LEN && n_cnt == 32'd0);
                end
                if (!(have && rkind == pngcc_pkg::RK_PASS)) ckind = pngcc_pkg::CK_OTHER;
                have = 1'b1; rkind = pngcc_pkg::RK_END; dbyte = 8'd0;
                n_phase = pngcc_pkg::PH_DONE;
            end
        end
    end

    assign o_have = have;
    always_comb begin
        o_res.result_kind = rkind;
        o_res.data_byte = dbyte;
        o_res.chunk_kind = ckind;
        o_res.image_width = n_hw;
        o_res.image_height = n_hh;
        o_res.bit_depth = n_hd;
        o_res.color_type = n_hc[2:0];
        o_res.channel_count = n_hch;
        o_res.status = status;
        o_res.truncated = trunc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pngcc_pkg::PH_SIG; r_sig_idx <= 3'd0; r_cnt <= 32'd0;
            r_len <= 32'd0; r_type <= 32'd0; r_crc <= pngcc_pkg::CRC_ONES;
            r_scrc <= 32'd0; r_pw <= 32'd0; r_ph <= 32'd0; r_pd <= 8'd0;
            r_pc <= 8'd0; r_pbad <= 1'b0; r_hw <= 32'd0; r_hh <= 32'd0;
            r_hd <= 8'd0; r_hc <= 8'd0; r_hch <= 3'd0; r_seen <= 1'b0;
        end else begin
            r_phase <= n_phase; r_sig_idx <= n_sig_idx; r_cnt <= n_cnt;
            r_len <= n_len; r_type <= n_type; r_crc <= n_crc; r_scrc <= n_scrc;
            r_pw <= n_pw; r_ph <= n_ph; r_pd <= n_pd; r_pc <= n_pc;
            r_pbad <= n_pbad; r_hw <= n_hw; r_hh <= n_hh; r_hd <= n_hd;
            r_hc <= n_hc; r_hch <= n_hch; r_seen <= n_seen;
        end
    end

endmodule

[hw/rtl/pngcc_queue.sv]
// pngcc_queue: short result queue between the parser and the output side
// depends on pngcc_pkg
module pngcc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pngcc_pkg::t_result  i_data,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output pngcc_pkg::t_result  o_data
);

    pngcc_pkg::t_result r_mem [pngcc_pkg::QDEPTH];
    logic [pngcc_pkg::QAW-1:0] r_wp, r_rp;
    logic [pngcc_pkg::QAW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full = (r_cnt == 3'(pngcc_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

[hw/rtl/png_chunk_stream_checker_unit.sv]
// png_chunk_stream_checker_unit: top level of the png chunk checker
// depends on pngcc_pkg, pngcc_front and pngcc_queue
//
// input side is a queue write port: a byte transfers when push is high and
// full is low; i_in_last marks the final byte of the file
// results come out as a queue read port: while empty is low the oldest
// result is on the o_ ports, and it transfers when pop is high
// each byte is parsed and crc-checked in the cycle it is taken, one byte
// per cycle while full is low; a result appears in the cycle after its byte
// (zero or one result per byte) and waits in a four-entry queue
// full rises only when the result queue holds four items, so a stalled
// receiver holds the input back after four results
// reset clears the parser to the signature phase and empties the queue
// after the end result all further bytes are taken and ignored
module png_chunk_stream_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_chunk_kind,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height,
    output logic [7:0]  o_bit_depth,
    output logic [2:0]  o_color_type,
    output logic [2:0]  o_channel_count,
    output logic [2:0]  o_status,
    output logic        o_truncated
);

    logic               acc, have;
    pngcc_pkg::t_result res, qout;

    assign acc = push && !full;

    pngcc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc), .i_byte(i_in_byte),
        .i_last(i_in_last), .o_have(have), .o_res(res)
    );

    pngcc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(have), .i_data(res),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_data(qout)
    );

    assign o_result_kind = qout.result_kind;
    assign o_data_byte = qout.data_byte;
    assign o_chunk_kind = qout.chunk_kind;
    assign o_image_width = qout.image_width;
    assign o_image_height = qout.image_height;
    assign o_bit_depth = qout.bit_depth;
    assign o_color_type = qout.color_type;
    assign o_channel_count = qout.channel_count;
    assign o_status = qout.status;
    assign o_truncated = qout.truncated;

endmodule
